// ===== rtl/fogb_pkg.sv =====
// Shared types, constants and register codes for the distance fog unit.
// Used by every module under rtl; depends on nothing.
package fogb_pkg;

    localparam int DIST_W     = 16;
    localparam int FACT_W     = 17;
    localparam logic [FACT_W-1:0] FACT_ONE = 17'd65536;
    localparam logic [FACT_W-1:0] FACT_MAX = 17'd65535;

    // exponential pipeline shape
    localparam int TERMS       = 20;
    localparam int STEP_STAGES = 6;
    localparam int SQUARINGS   = 4;
    localparam int SQ_STAGES   = 3;
    localparam int EXP_LAT     = 2 + TERMS * STEP_STAGES + SQUARINGS * SQ_STAGES + 1;

    // linear divider shape
    localparam int LIN_BITS  = 2;
    localparam int LIN_STEPS = 16 / LIN_BITS;
    localparam int LIN_PAD   = EXP_LAT - (1 + LIN_STEPS);

    localparam int BLEND_LAT = 2;
    localparam int OUT_LAT   = 1 + EXP_LAT + BLEND_LAT;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_MODE,
        REG_START,
        REG_END,
        REG_DENSITY,
        REG_RED,
        REG_GREEN,
        REG_BLUE
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]        pixel_red;
        logic [7:0]        pixel_green;
        logic [7:0]        pixel_blue;
        logic [7:0]        pixel_alpha;
        logic [DIST_W-1:0] view_distance;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } result_t;

    typedef struct packed {
        logic        fog_enable;
        logic        fog_mode;
        logic [15:0] fog_start;
        logic [15:0] fog_end;
        logic [15:0] fog_density;
        logic [7:0]  fog_red;
        logic [7:0]  fog_green;
        logic [7:0]  fog_blue;
    } fog_cfg_t;

    localparam fog_cfg_t CFG_RESET = '{
        fog_enable:  1'b0,
        fog_mode:    1'b0,
        fog_start:   16'd320,
        fog_end:     16'd800,
        fog_density: 16'd1311,
        fog_red:     8'd20,
        fog_green:   8'd20,
        fog_blue:    8'd30
    };

endpackage

// ===== rtl/fogb_exp.sv =====
// Exponential fog factor pipeline: 1 - exp(-density * d) in Q0.16.
// Depends on fogb_pkg.
module fogb_exp
    import fogb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fog_cfg_t          cfg,
    input  logic              in_vld,
    input  logic [DIST_W-1:0] distance,
    output logic              out_vld,
    output logic [FACT_W-1:0] factor
);

    localparam logic [62:0] Q62_ONE   = 63'd1 << 62;
    localparam logic [31:0] EXP_LIMIT = 32'd12 << 20;

    typedef struct packed {
        logic        big;
        logic [23:0] n;
        logic [62:0] t;
    } tap_t;

    // one radix-2^16 digit of a division by a small constant k
    function automatic logic [20:0] digit_div(
        input logic [4:0]  rem,
        input logic [15:0] chunk,
        input logic [26:0] recip,
        input logic [4:0]  k
    );
        logic [20:0] v;
        logic [47:0] prod;
        logic [15:0] qd;
        logic [20:0] back;
        logic [4:0]  r;
        v    = {rem, chunk};
        prod = 48'(v) * 48'(recip);
        qd   = prod[41:26];
        back = 21'(qd) * 21'(k);
        r    = 5'(v - back);
        return {qd, r};
    endfunction

    logic        n0_vld_reg;
    logic [31:0] n0_reg;

    tap_t tap_reg     [0:TERMS];
    logic tap_vld_reg [0:TERMS];

    logic [62:0] sq_t_reg   [0:SQUARINGS-1];
    logic        sq_big_reg [0:SQUARINGS-1];
    logic        sq_vld_reg [0:SQUARINGS-1];

    logic              f_vld_reg;
    logic [FACT_W-1:0] f_reg;

    // scale the distance by the density
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n0_vld_reg     <= 1'b0;
            tap_vld_reg[0] <= 1'b0;
        end
        else
        begin
            n0_vld_reg     <= in_vld;
            tap_vld_reg[0] <= n0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n0_reg         <= 32'(cfg.fog_density) * 32'(distance);
        tap_reg[0].big <= (n0_reg >= EXP_LIMIT);
        tap_reg[0].n   <= n0_reg[23:0];
        tap_reg[0].t   <= Q62_ONE;
    end

    // Horner steps of the series, highest term first
    for (genvar j = 0; j < TERMS; j++)
    begin : g_term
        localparam int K = TERMS - j;
        localparam logic [26:0] RECIP = 27'(((64'd1 << 26) + 64'(K - 1)) / K);
        localparam logic [4:0]  KV    = 5'(K);

        logic        h0_vld_reg;
        logic        h0_big_reg;
        logic [23:0] h0_n_reg;
        logic [54:0] h0_ph_reg;
        logic [55:0] h0_pl_reg;

        logic        h1_vld_reg;
        logic        h1_big_reg;
        logic [23:0] h1_n_reg;
        logic [63:0] h1_q_reg;

        logic        d_vld_reg  [0:2];
        logic        d_big_reg  [0:2];
        logic [23:0] d_n_reg    [0:2];
        logic [63:0] d_q_reg    [0:2];
        logic [63:0] d_quot_reg [0:2];
        logic [4:0]  d_rem_reg  [0:2];

        logic [86:0] prod_sum;
        logic [4:0]  in_rem  [0:3];
        logic [63:0] in_q    [0:3];
        logic [63:0] in_quot [0:3];
        logic [15:0] qd      [0:3];
        logic [4:0]  rd      [0:3];
        logic [63:0] quot_nx [0:3];

        assign prod_sum = {h0_ph_reg, 32'd0} + 87'(h0_pl_reg);

        always_comb
        begin
            in_rem[0]  = 5'd0;
            in_q[0]    = h1_q_reg;
            in_quot[0] = 64'd0;
            for (int c = 1; c < 4; c++)
            begin
                in_rem[c]  = d_rem_reg[c-1];
                in_q[c]    = d_q_reg[c-1];
                in_quot[c] = d_quot_reg[c-1];
            end
            for (int c = 0; c < 4; c++)
            begin
                {qd[c], rd[c]} = digit_div(in_rem[c], in_q[c][63 - 16*c -: 16], RECIP, KV);
                quot_nx[c]     = in_quot[c] | (64'(qd[c]) << (48 - 16*c));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                h0_vld_reg <= 1'b0;
                h1_vld_reg <= 1'b0;
                for (int c = 0; c < 3; c++)
                begin
                    d_vld_reg[c] <= 1'b0;
                end
                tap_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                h0_vld_reg   <= tap_vld_reg[j];
                h1_vld_reg   <= h0_vld_reg;
                d_vld_reg[0] <= h1_vld_reg;
                for (int c = 1; c < 3; c++)
                begin
                    d_vld_reg[c] <= d_vld_reg[c-1];
                end
                tap_vld_reg[j+1] <= d_vld_reg[2];
            end
        end

        always_ff @(posedge clk)
        begin
            // n * t, split into two partial products
            h0_big_reg <= tap_reg[j].big;
            h0_n_reg   <= tap_reg[j].n;
            h0_ph_reg  <= 55'(tap_reg[j].n) * 55'(tap_reg[j].t[62:32]);
            h0_pl_reg  <= 56'(tap_reg[j].n) * 56'(tap_reg[j].t[31:0]);
            // product scaled back to Q62
            h1_big_reg <= h0_big_reg;
            h1_n_reg   <= h0_n_reg;
            h1_q_reg   <= 64'(prod_sum[86:24]);
            // divide by k one 16-bit digit per stage
            d_big_reg[0] <= h1_big_reg;
            d_n_reg[0]   <= h1_n_reg;
            for (int c = 1; c < 3; c++)
            begin
                d_big_reg[c] <= d_big_reg[c-1];
                d_n_reg[c]   <= d_n_reg[c-1];
            end
            for (int c = 0; c < 3; c++)
            begin
                d_q_reg[c]    <= in_q[c];
                d_quot_reg[c] <= quot_nx[c];
                d_rem_reg[c]  <= rd[c];
            end
            tap_reg[j+1].big <= d_big_reg[2];
            tap_reg[j+1].n   <= d_n_reg[2];
            tap_reg[j+1].t   <= Q62_ONE - quot_nx[3][62:0];
        end
    end

    // four squarings undo the scaling of the argument by 1/16
    for (genvar i = 0; i < SQUARINGS; i++)
    begin : g_sq
        logic        src_vld;
        logic        src_big;
        logic [62:0] src_t;

        logic        a_vld_reg;
        logic        a_big_reg;
        logic [30:0] a_th_reg;
        logic [63:0] a_ll_reg;
        logic [62:0] a_lh_reg;

        logic        b_vld_reg;
        logic        b_big_reg;
        logic [61:0] b_hh_reg;
        logic [96:0] b_mid_reg;

        logic [125:0] full;

        if (i == 0)
        begin : g_src_first
            assign src_vld = tap_vld_reg[TERMS];
            assign src_big = tap_reg[TERMS].big;
            assign src_t   = tap_reg[TERMS].t;
        end
        else
        begin : g_src_next
            assign src_vld = sq_vld_reg[i-1];
            assign src_big = sq_big_reg[i-1];
            assign src_t   = sq_t_reg[i-1];
        end

        assign full = {b_hh_reg, 64'd0} + 126'(b_mid_reg);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg     <= 1'b0;
                b_vld_reg     <= 1'b0;
                sq_vld_reg[i] <= 1'b0;
            end
            else
            begin
                a_vld_reg     <= src_vld;
                b_vld_reg     <= a_vld_reg;
                sq_vld_reg[i] <= b_vld_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            a_big_reg     <= src_big;
            a_th_reg      <= src_t[62:32];
            a_ll_reg      <= 64'(src_t[31:0]) * 64'(src_t[31:0]);
            a_lh_reg      <= 63'(src_t[62:32]) * 63'(src_t[31:0]);
            b_big_reg     <= a_big_reg;
            b_hh_reg      <= 62'(a_th_reg) * 62'(a_th_reg);
            b_mid_reg     <= 97'(a_ll_reg) + {1'b0, a_lh_reg, 33'd0};
            sq_big_reg[i] <= b_big_reg;
            sq_t_reg[i]   <= full[124:62];
        end
    end

    logic [62:0] e_clip;
    logic [62:0] e_diff;

    assign e_clip = (sq_t_reg[SQUARINGS-1] > Q62_ONE) ? Q62_ONE : sq_t_reg[SQUARINGS-1];
    assign e_diff = Q62_ONE - e_clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= sq_vld_reg[SQUARINGS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_big_reg[SQUARINGS-1] || (e_diff[62:46] > FACT_MAX))
        begin
            f_reg <= FACT_MAX;
        end
        else
        begin
            f_reg <= e_diff[62:46];
        end
    end

    assign out_vld = f_vld_reg;
    assign factor  = f_reg;

endmodule

// ===== rtl/fogb_lin.sv =====
// Linear fog factor: clamp((d - start) / (end - start)) in Q0.16 via a
// pipelined restoring divider, padded to the exponential latency. Depends on fogb_pkg.
module fogb_lin
    import fogb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fog_cfg_t          cfg,
    input  logic              in_vld,
    input  logic [DIST_W-1:0] distance,
    output logic              out_vld,
    output logic [FACT_W-1:0] factor
);

    function automatic logic [31:0] div_step(
        input logic [15:0] rem,
        input logic [15:0] quot,
        input logic [15:0] den
    );
        logic [16:0] r2;
        logic [15:0] r;
        logic [15:0] q;
        r = rem;
        q = quot;
        for (int b = 0; b < LIN_BITS; b++)
        begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, den})
            begin
                r = 16'(r2 - {1'b0, den});
                q = {q[14:0], 1'b1};
            end
            else
            begin
                r = r2[15:0];
                q = {q[14:0], 1'b0};
            end
        end
        return {r, q};
    endfunction

    logic [15:0] den;

    logic        p_vld_reg;
    logic        p_zero_reg;
    logic        p_full_reg;
    logic [15:0] p_rem_reg;

    logic        s_vld_reg  [0:LIN_STEPS-1];
    logic        s_zero_reg [0:LIN_STEPS-1];
    logic        s_full_reg [0:LIN_STEPS-1];
    logic [15:0] s_rem_reg  [0:LIN_STEPS-1];
    logic [15:0] s_quot_reg [0:LIN_STEPS-1];

    logic [31:0] s_next [0:LIN_STEPS-1];

    logic              pad_vld_reg [0:LIN_PAD-1];
    logic [FACT_W-1:0] pad_f_reg   [0:LIN_PAD-1];

    assign den = cfg.fog_end - cfg.fog_start;

    always_comb
    begin
        s_next[0] = div_step(p_rem_reg, 16'd0, den);
        for (int s = 1; s < LIN_STEPS; s++)
        begin
            s_next[s] = div_step(s_rem_reg[s-1], s_quot_reg[s-1], den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            for (int s = 0; s < LIN_STEPS; s++)
            begin
                s_vld_reg[s] <= 1'b0;
            end
            for (int s = 0; s < LIN_PAD; s++)
            begin
                pad_vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            p_vld_reg    <= in_vld;
            s_vld_reg[0] <= p_vld_reg;
            for (int s = 1; s < LIN_STEPS; s++)
            begin
                s_vld_reg[s] <= s_vld_reg[s-1];
            end
            pad_vld_reg[0] <= s_vld_reg[LIN_STEPS-1];
            for (int s = 1; s < LIN_PAD; s++)
            begin
                pad_vld_reg[s] <= pad_vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_zero_reg <= (cfg.fog_end <= cfg.fog_start) || (distance <= cfg.fog_start);
        p_full_reg <= (distance >= cfg.fog_end);
        p_rem_reg  <= distance - cfg.fog_start;

        s_zero_reg[0] <= p_zero_reg;
        s_full_reg[0] <= p_full_reg;
        for (int s = 1; s < LIN_STEPS; s++)
        begin
            s_zero_reg[s] <= s_zero_reg[s-1];
            s_full_reg[s] <= s_full_reg[s-1];
        end
        for (int s = 0; s < LIN_STEPS; s++)
        begin
            s_rem_reg[s]  <= s_next[s][31:16];
            s_quot_reg[s] <= s_next[s][15:0];
        end

        // clamp, then hold until the exponential path catches up
        if (s_zero_reg[LIN_STEPS-1])
        begin
            pad_f_reg[0] <= '0;
        end
        else if (s_full_reg[LIN_STEPS-1])
        begin
            pad_f_reg[0] <= FACT_ONE;
        end
        else
        begin
            pad_f_reg[0] <= {1'b0, s_quot_reg[LIN_STEPS-1]};
        end
        for (int s = 1; s < LIN_PAD; s++)
        begin
            pad_f_reg[s] <= pad_f_reg[s-1];
        end
    end

    assign out_vld = pad_vld_reg[LIN_PAD-1];
    assign factor  = pad_f_reg[LIN_PAD-1];

endmodule

// ===== rtl/fogb_blend.sv =====
// Color blend stages: mix each RGB channel toward the fog color (raw when fog is disabled), pass alpha.
// Depends on fogb_pkg.
module fogb_blend
    import fogb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fog_cfg_t          cfg,
    input  logic              in_vld,
    input  pixel_t            pix,
    input  logic [FACT_W-1:0] lin_f,
    input  logic [FACT_W-1:0] exp_f,
    output logic              out_vld,
    output result_t           res
);

    logic [FACT_W-1:0] f;
    logic [7:0]        p_ch [0:2];
    logic [7:0]        c_ch [0:2];

    logic        m_vld_reg;
    logic [24:0] m_pix_reg [0:2];
    logic [24:0] m_fog_reg [0:2];
    logic [7:0]  m_raw_reg [0:2];
    logic [7:0]  m_alpha_reg;

    logic [24:0] mix [0:2];
    logic [7:0]  ch_out [0:2];

    logic    done_reg;
    result_t res_reg;

    assign f = cfg.fog_mode ? exp_f : lin_f;

    assign p_ch[0] = pix.pixel_red;
    assign p_ch[1] = pix.pixel_green;
    assign p_ch[2] = pix.pixel_blue;
    assign c_ch[0] = cfg.fog_red;
    assign c_ch[1] = cfg.fog_green;
    assign c_ch[2] = cfg.fog_blue;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mix[c]    = m_pix_reg[c] + m_fog_reg[c];
            ch_out[c] = cfg.fog_enable ? mix[c][23:16] : m_raw_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            m_vld_reg <= in_vld;
            done_reg  <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            m_pix_reg[c] <= 25'(p_ch[c]) * 25'(FACT_ONE - f);
            m_fog_reg[c] <= 25'(c_ch[c]) * 25'(f);
            m_raw_reg[c] <= p_ch[c];
        end
        m_alpha_reg <= pix.pixel_alpha;

        res_reg.out_red   <= ch_out[0];
        res_reg.out_green <= ch_out[1];
        res_reg.out_blue  <= ch_out[2];
        res_reg.out_alpha <= m_alpha_reg;
    end

    assign out_vld = done_reg;
    assign res     = res_reg;

endmodule

// ===== rtl/distance_fog_blend.sv =====
// Top level of the per-pixel distance fog unit: config registers, input
// register, pixel side line and the factor and blend pipelines. Depends on fogb_pkg.
//
// Usage:
//   Input channel: drive pixel and pulse start; a word is taken at each rising
//   edge with start high and busy low. Busy is low whenever out of reset, so a
//   word may enter every cycle (one pixel per clock sustained).
//   Result channel: done is high for exactly one cycle with the fogged word on
//   result. The receiver cannot stall; the pipeline never holds.
//   Depth: set by the exponential path: 20 series terms of 6 stages (split
//   multiply, rescale, four 16-bit digits of a constant divide), four squarings
//   of 3 stages, plus input and blend stages.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0 enable, 1 mode, 2 start, 3 end, 4 density, 5..7 fog
//   color; other indexes are dropped. Write only while no pixel is in flight.
//   Reset: clears all valid bits, loads default registers, and holds busy high
//   until the first edge after release.
module distance_fog_blend
    import fogb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pixel_t                pixel,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fog_cfg_t cfg_reg;
    logic     busy_reg;
    logic     accept;

    logic   in_vld_reg;
    pixel_t in_pix_reg;

    // pixel words ride alongside the factor pipelines
    pixel_t side_reg [0:EXP_LAT-1];

    logic              exp_vld;
    logic [FACT_W-1:0] exp_f;
    logic              lin_vld;
    logic [FACT_W-1:0] lin_f;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    // register file; out-of-range indexes fall through to the default arm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ENABLE:  cfg_reg.fog_enable  <= cfg_data[0];
                REG_MODE:    cfg_reg.fog_mode    <= cfg_data[0];
                REG_START:   cfg_reg.fog_start   <= cfg_data;
                REG_END:     cfg_reg.fog_end     <= cfg_data;
                REG_DENSITY: cfg_reg.fog_density <= cfg_data;
                REG_RED:     cfg_reg.fog_red     <= cfg_data[7:0];
                REG_GREEN:   cfg_reg.fog_green   <= cfg_data[7:0];
                REG_BLUE:    cfg_reg.fog_blue    <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= 1'b0;
            in_vld_reg <= accept;
        end
    end

    // advance the side line every cycle
    always_ff @(posedge clk)
    begin
        in_pix_reg  <= pixel;
        side_reg[0] <= in_pix_reg;
        for (int s = 1; s < EXP_LAT; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
    end

    fogb_exp u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_vld   (in_vld_reg),
        .distance (in_pix_reg.view_distance),
        .out_vld  (exp_vld),
        .factor   (exp_f)
    );

    fogb_lin u_lin (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_vld   (in_vld_reg),
        .distance (in_pix_reg.view_distance),
        .out_vld  (lin_vld),
        .factor   (lin_f)
    );

    fogb_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_vld  (exp_vld),
        .pix     (side_reg[EXP_LAT-1]),
        .lin_f   (lin_f),
        .exp_f   (exp_f),
        .out_vld (done),
        .res     (result)
    );

    // both factor paths must deliver the same word in the same cycle
    a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        exp_vld == lin_vld)
        else $error("factor paths out of step");

    // every accepted word comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##OUT_LAT done)
        else $error("accepted word did not complete on time");

    // no result without a matching accept
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, OUT_LAT))
        else $error("result strobe without an accepted word");

    // alpha stays matched to its own pixel through the side line
    a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.out_alpha == $past(pixel.pixel_alpha, OUT_LAT))
        else $error("alpha does not match its pixel");

endmodule
